// ===== hw/rtl/fpga_serial_config_sequencer_core_defines.svh =====
`ifndef FPGA_SERIAL_CONFIG_SEQUENCER_CORE_DEFINES_SVH
`define FPGA_SERIAL_CONFIG_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FSCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define FSCS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fscs_pkg.sv =====
`default_nettype none

package fscs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TICK_W     = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOW_TO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HIGH_TO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILING     = 3'd5;

    localparam logic [15:0] RST_PROG_HIGH    = 16'd10;
    localparam logic [15:0] RST_PROG_LOW     = 16'd5;
    localparam logic [15:0] RST_INIT_LOW_TO  = 16'd200;
    localparam logic [15:0] RST_SETTLE       = 16'd5;
    localparam logic [23:0] RST_INIT_HIGH_TO = 24'hFFFFFF;
    localparam logic [7:0]  RST_TRAILING     = 8'd50;

    // request function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_BYTE  = 2'd2;

    // index of the final result of a request
    localparam logic [3:0] LAST_IDX_SINGLE = 4'd0;
    localparam logic [3:0] LAST_IDX_PAIR   = 4'd1;
    localparam logic [3:0] LAST_IDX_BYTE   = 4'd15;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_PROG_HIGH  = 3'd1,
        PH_PROG_LOW   = 3'd2,
        PH_WAIT_INITL = 3'd3,
        PH_SETTLE     = 3'd4,
        PH_WAIT_INITH = 3'd5,
        PH_SHIFT      = 3'd6,
        PH_TRAILING   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_BUSY        = 3'd1,
        ST_INIT_STUCKH = 3'd2,
        ST_INIT_STUCKL = 3'd3,
        ST_SUCCESS     = 3'd4,
        ST_DONE_MISS   = 3'd5,
        ST_BYTE_REJECT = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0] prog_high;
        logic [15:0] prog_low;
        logic [15:0] init_low_to;
        logic [15:0] settle;
        logic [23:0] init_high_to;
        logic [7:0]  trailing;
    } cfg_t;

    // what the serializer needs to replay the results of one request
    typedef struct packed {
        logic        prog;
        logic        cclk;
        logic        dout;
        logic        is_byte;
        logic [3:0]  last_idx;
        logic [7:0]  data;
        phase_t      phase;
        status_t     status;
    } desc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fscs_regs.sv =====
`default_nettype none

module fscs_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [fscs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fscs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output fscs_pkg::cfg_t                      cfg
);
    import fscs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prog_high    <= RST_PROG_HIGH;
            cfg_reg.prog_low     <= RST_PROG_LOW;
            cfg_reg.init_low_to  <= RST_INIT_LOW_TO;
            cfg_reg.settle       <= RST_SETTLE;
            cfg_reg.init_high_to <= RST_INIT_HIGH_TO;
            cfg_reg.trailing     <= RST_TRAILING;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PROG_HIGH:    cfg_reg.prog_high    <= cfg_wdata[15:0];
                CFG_PROG_LOW:     cfg_reg.prog_low     <= cfg_wdata[15:0];
                CFG_INIT_LOW_TO:  cfg_reg.init_low_to  <= cfg_wdata[15:0];
                CFG_SETTLE:       cfg_reg.settle       <= cfg_wdata[15:0];
                CFG_INIT_HIGH_TO: cfg_reg.init_high_to <= cfg_wdata[23:0];
                CFG_TRAILING:     cfg_reg.trailing     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fscs_seq.sv =====
`default_nettype none

module fscs_seq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire fscs_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_func,
    input  wire logic           in_init,
    input  wire logic           in_done,
    input  wire logic [7:0]     in_data,
    input  wire logic           in_last,
    input  wire logic           desc_pop,
    output logic                desc_valid,
    output fscs_pkg::desc_t     desc
);
    import fscs_pkg::*;

    phase_t              phase_reg, phase_next;
    status_t             status_reg, status_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic                prog_reg, prog_next;
    logic                cclk_reg, cclk_next;
    logic                dout_reg, dout_next;
    logic                desc_valid_reg;
    desc_t               desc_reg, desc_next;

    logic [TICK_W-1:0]   tick_inc;
    logic [TICK_W-1:0]   limit;
    logic                reached;
    logic                accept;

    assign in_ready = !desc_valid_reg || desc_pop;
    assign accept   = in_valid && in_ready;
    assign tick_inc = tick_reg + TICK_W'(1);

    always_comb begin
        unique case (phase_reg)
            PH_PROG_HIGH:  limit = TICK_W'(cfg.prog_high);
            PH_PROG_LOW:   limit = TICK_W'(cfg.prog_low);
            PH_WAIT_INITL: limit = TICK_W'(cfg.init_low_to);
            PH_SETTLE:     limit = TICK_W'(cfg.settle);
            default:       limit = cfg.init_high_to;
        endcase
    end

    assign reached = tick_inc >= limit;

    always_comb begin
        phase_next  = phase_reg;
        status_next = status_reg;
        tick_next   = tick_reg;
        prog_next   = prog_reg;
        cclk_next   = cclk_reg;
        dout_next   = dout_reg;
        desc_next.is_byte  = 1'b0;
        desc_next.last_idx = LAST_IDX_SINGLE;
        desc_next.data     = in_data;
        desc_next.prog     = 1'b0;
        desc_next.cclk     = 1'b0;
        desc_next.dout     = 1'b0;

        unique case (in_func)
            FUNC_START: begin
                prog_next   = 1'b1;
                cclk_next   = 1'b0;
                status_next = ST_BUSY;
                phase_next  = PH_PROG_HIGH;
                tick_next   = '0;
            end
            FUNC_TICK: begin
                unique case (phase_reg)
                    PH_PROG_HIGH: begin
                        tick_next = tick_inc;
                        if (reached) begin
                            prog_next  = 1'b0;
                            phase_next = PH_PROG_LOW;
                            tick_next  = '0;
                        end
                    end
                    PH_PROG_LOW: begin
                        tick_next = tick_inc;
                        if (reached) begin
                            phase_next = PH_WAIT_INITL;
                            tick_next  = '0;
                        end
                    end
                    PH_WAIT_INITL: begin
                        if (!in_init) begin
                            phase_next = PH_SETTLE;
                            tick_next  = '0;
                        end else if (reached) begin
                            prog_next   = 1'b1;
                            status_next = ST_INIT_STUCKH;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_SETTLE: begin
                        tick_next = tick_inc;
                        if (reached) begin
                            prog_next  = 1'b1;
                            phase_next = PH_WAIT_INITH;
                            tick_next  = '0;
                        end
                    end
                    PH_WAIT_INITH: begin
                        if (in_init) begin
                            phase_next = PH_SHIFT;
                            tick_next  = '0;
                        end else if (reached) begin
                            status_next = ST_INIT_STUCKL;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_TRAILING: begin
                        if (tick_reg < TICK_W'(cfg.trailing)) begin
                            // one full clock: low then high
                            tick_next          = tick_inc;
                            cclk_next          = 1'b1;
                            desc_next.last_idx = LAST_IDX_PAIR;
                        end else begin
                            cclk_next   = 1'b0;
                            dout_next   = 1'b0;
                            status_next = in_done ? ST_SUCCESS : ST_DONE_MISS;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_BYTE: begin
                if (phase_reg == PH_SHIFT) begin
                    if (in_last) begin
                        phase_next = PH_TRAILING;
                        tick_next  = '0;
                    end
                    cclk_next          = 1'b1;
                    dout_next          = in_data[0];
                    desc_next.is_byte  = 1'b1;
                    desc_next.last_idx = LAST_IDX_BYTE;
                end else begin
                    prog_next   = 1'b1;
                    cclk_next   = 1'b0;
                    dout_next   = 1'b0;
                    status_next = ST_BYTE_REJECT;
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                end
            end
            default: ;
        endcase

        desc_next.phase  = phase_next;
        desc_next.status = status_next;
        if (desc_next.last_idx == LAST_IDX_SINGLE) begin
            desc_next.prog = prog_next;
            desc_next.cclk = cclk_next;
            desc_next.dout = dout_next;
        end else begin
            // multi-result requests replay from the pin state before the request
            desc_next.prog = prog_reg;
            desc_next.cclk = 1'b0;
            desc_next.dout = dout_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            status_reg     <= ST_IDLE;
            tick_reg       <= '0;
            prog_reg       <= 1'b1;
            cclk_reg       <= 1'b0;
            dout_reg       <= 1'b0;
            desc_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                status_reg <= status_next;
                tick_reg   <= tick_next;
                prog_reg   <= prog_next;
                cclk_reg   <= cclk_next;
                dout_reg   <= dout_next;
            end
            if (accept) begin
                desc_valid_reg <= 1'b1;
            end else if (desc_pop) begin
                desc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fscs_ser.sv =====
`default_nettype none

module fscs_ser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        desc_valid,
    input  wire fscs_pkg::desc_t desc,
    output logic             desc_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_prog,
    output logic             out_cclk,
    output logic             out_dout,
    output fscs_pkg::phase_t  out_phase,
    output fscs_pkg::status_t out_status,
    output logic             out_last
);
    import fscs_pkg::*;

    desc_t       cur_reg;
    logic [3:0]  idx_reg;
    logic        valid_reg;
    logic        fire;
    logic        at_last;

    assign at_last  = idx_reg == cur_reg.last_idx;
    assign fire     = valid_reg && out_ready;
    assign desc_pop = desc_valid && (!valid_reg || (fire && at_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (desc_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (fire) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (desc_pop) begin
            cur_reg <= desc;
        end
    end

    // even index: clock low with data set, odd index: clock high
    assign out_valid  = valid_reg;
    assign out_prog   = cur_reg.prog;
    assign out_cclk   = (cur_reg.last_idx == LAST_IDX_SINGLE) ? cur_reg.cclk : idx_reg[0];
    assign out_dout   = cur_reg.is_byte ? cur_reg.data[~idx_reg[3:1]] : cur_reg.dout;
    assign out_phase  = cur_reg.phase;
    assign out_status = cur_reg.status;
    assign out_last   = at_last;

endmodule

`default_nettype wire

// ===== hw/rtl/fpga_serial_config_sequencer_core.sv =====
// an accepted request passes the descriptor register, then the result register, to reach m_
// throughput: one request per cycle for single-result requests while m_tready is high;
// a tick in the trailing phase gives two pin states, a byte sixteen, one result each
// a descriptor register lets the next request in while a result still waits
// reset: synchronous active-low aresetn; registers back to their defaults, phase idle,
// PROG high, clock and data low, both channels empty
`default_nettype none

module fpga_serial_config_sequencer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [fscs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fscs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [0] init_level, [1] done_level, [9:2] data_byte, [15:10] zero
    input  wire logic [15:0]                    s_tdata,
    // [1:0] func
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] prog_level, [1] cclk_level, [2] dout_level, [5:3] phase, [8:6] status, [15:9] zero
    output logic [15:0]                         m_tdata,
    output logic                                m_tlast
);
    import fscs_pkg::*;

    cfg_t     cfg;
    desc_t    desc;
    logic     desc_valid;
    logic     desc_pop;
    logic     out_prog;
    logic     out_cclk;
    logic     out_dout;
    phase_t   out_phase;
    status_t  out_status;

    fscs_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fscs_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_init    (s_tdata[0]),
        .in_done    (s_tdata[1]),
        .in_data    (s_tdata[9:2]),
        .in_last    (s_tlast),
        .desc_pop   (desc_pop),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    fscs_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_prog   (out_prog),
        .out_cclk   (out_cclk),
        .out_dout   (out_dout),
        .out_phase  (out_phase),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, out_status, out_phase, out_dout, out_cclk, out_prog};

endmodule

`default_nettype wire

// ===== hw/rtl/fscs_checker.sv =====
`default_nettype none
`include "fpga_serial_config_sequencer_core_defines.svh"

module fscs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);
    import fscs_pkg::*;

    logic [2:0] phase_f;
    logic [2:0] status_f;

    assign phase_f  = m_tdata[5:3];
    assign status_f = m_tdata[8:6];

    // any active phase reports busy
    `FSCS_ASSERT_NOW(a_busy_in_phase, m_tvalid && phase_f != PH_IDLE, status_f == ST_BUSY, "active phase without busy status")
    `FSCS_ASSERT_NOW(a_status_code, m_tvalid, status_f != 3'd7, "undefined status code")
    `FSCS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `FSCS_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind fpga_serial_config_sequencer_core fscs_checker u_fscs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import fscs_pkg::*;

    // selector value the block ignores
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        bit      prog;
        bit      cclk;
        bit      dout;
        phase_t  phase;
        status_t status;
        bit      last;
    } pin_result_t;

    class pin_state_predictor;
        logic [15:0] prog_high_lim, prog_low_lim, init_low_lim, settle_lim;
        logic [23:0] init_high_lim;
        logic [7:0]  trail_lim;
        phase_t      phase;
        status_t     status;
        logic [23:0] ticks;
        bit          prog, cclk, dout;
        pin_result_t expected_pins[$];
        int          errors, checked, requests;
        int          outcomes[8];

        function new();
            prog_high_lim = RST_PROG_HIGH;
            prog_low_lim  = RST_PROG_LOW;
            init_low_lim  = RST_INIT_LOW_TO;
            settle_lim    = RST_SETTLE;
            init_high_lim = RST_INIT_HIGH_TO;
            trail_lim     = RST_TRAILING;
            phase = PH_IDLE;
            status = ST_IDLE;
            ticks = '0;
            prog = 1'b1;
            cclk = 1'b0;
            dout = 1'b0;
            errors = 0;
            checked = 0;
            requests = 0;
            foreach (outcomes[i]) outcomes[i] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                CFG_PROG_HIGH:    prog_high_lim = val[15:0];
                CFG_PROG_LOW:     prog_low_lim  = val[15:0];
                CFG_INIT_LOW_TO:  init_low_lim  = val[15:0];
                CFG_SETTLE:       settle_lim    = val[15:0];
                CFG_INIT_HIGH_TO: init_high_lim = val;
                CFG_TRAILING:     trail_lim     = val[7:0];
                default: ;
            endcase
        endfunction

        function void push_pins();
            pin_result_t r;
            r.prog = prog;
            r.cclk = cclk;
            r.dout = dout;
            r.phase = phase;
            r.status = status;
            r.last = 1'b0;
            expected_pins.push_back(r);
        endfunction

        function bit count_tick(logic [23:0] limit);
            ticks = ticks + 24'd1;
            return ticks >= limit;
        endfunction

        function void enter(phase_t p);
            phase = p;
            ticks = '0;
        endfunction

        function void finish_with(status_t s);
            status = s;
            outcomes[s]++;
        endfunction

        function void note_request(logic [1:0] func, bit init_lv, bit done_lv,
                                   logic [7:0] data, bit last);
            requests++;
            case (func)
                FUNC_START: begin
                    prog = 1'b1;
                    cclk = 1'b0;
                    status = ST_BUSY;
                    enter(PH_PROG_HIGH);
                    push_pins();
                end
                FUNC_TICK: begin
                    case (phase)
                        PH_PROG_HIGH:
                            if (count_tick({8'd0, prog_high_lim})) begin
                                prog = 1'b0;
                                enter(PH_PROG_LOW);
                            end
                        PH_PROG_LOW:
                            if (count_tick({8'd0, prog_low_lim})) enter(PH_WAIT_INITL);
                        PH_WAIT_INITL:
                            if (!init_lv) enter(PH_SETTLE);
                            else if (count_tick({8'd0, init_low_lim})) begin
                                prog = 1'b1;
                                finish_with(ST_INIT_STUCKH);
                                enter(PH_IDLE);
                            end
                        PH_SETTLE:
                            if (count_tick({8'd0, settle_lim})) begin
                                prog = 1'b1;
                                enter(PH_WAIT_INITH);
                            end
                        PH_WAIT_INITH:
                            if (init_lv) enter(PH_SHIFT);
                            else if (count_tick(init_high_lim)) begin
                                finish_with(ST_INIT_STUCKL);
                                enter(PH_IDLE);
                            end
                        PH_TRAILING:
                            if (ticks < {16'd0, trail_lim}) begin
                                ticks = ticks + 24'd1;
                                cclk = 1'b0;
                                push_pins();
                                cclk = 1'b1;
                            end else begin
                                cclk = 1'b0;
                                dout = 1'b0;
                                finish_with(done_lv ? ST_SUCCESS : ST_DONE_MISS);
                                enter(PH_IDLE);
                            end
                        default: ;
                    endcase
                    push_pins();
                end
                FUNC_BYTE: begin
                    if (phase == PH_SHIFT) begin
                        if (last) enter(PH_TRAILING);
                        for (int i = 7; i >= 0; i--) begin
                            cclk = 1'b0;
                            dout = data[i];
                            push_pins();
                            cclk = 1'b1;
                            push_pins();
                        end
                    end else begin
                        prog = 1'b1;
                        cclk = 1'b0;
                        dout = 1'b0;
                        finish_with(ST_BYTE_REJECT);
                        enter(PH_IDLE);
                        push_pins();
                    end
                end
                default: push_pins();
            endcase
            expected_pins[$].last = 1'b1;
        endfunction

        function void check_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pins(logic [15:0] data, logic last);
            pin_result_t want;
            if (expected_pins.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %h last %b", $time, data, last);
                return;
            end
            want = expected_pins.pop_front();
            checked++;
            check_field("prog_level", {2'd0, want.prog}, {2'd0, data[0]});
            check_field("cclk_level", {2'd0, want.cclk}, {2'd0, data[1]});
            check_field("dout_level", {2'd0, want.dout}, {2'd0, data[2]});
            check_field("phase", want.phase, data[5:3]);
            check_field("status", want.status, data[8:6]);
            check_field("last_of_run", {2'd0, want.last}, {2'd0, last});
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tlast;

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_off = 1'b0;
    int  hold_cnt = 0;
    int  settings = 0;
    pin_state_predictor pins_sb = new();

    fpga_serial_config_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_off && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pins_sb.check_pins(m_tdata, m_tlast);
    end

    task automatic put_reg(logic [2:0] idx, logic [23:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        pins_sb.set_reg(idx, val);
    endtask

    task automatic load_config(logic [15:0] ph, logic [15:0] pl, logic [15:0] il,
                               logic [15:0] st, logic [23:0] ih, logic [7:0] tr);
        cfg_we <= 1'b1;
        put_reg(CFG_PROG_HIGH, {8'd0, ph});
        put_reg(CFG_PROG_LOW, {8'd0, pl});
        put_reg(CFG_INIT_LOW_TO, {8'd0, il});
        put_reg(CFG_SETTLE, {8'd0, st});
        put_reg(CFG_INIT_HIGH_TO, ih);
        put_reg(CFG_TRAILING, {16'd0, tr});
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_request(logic [1:0] func, bit init_lv, bit done_lv,
                                logic [7:0] data, bit last);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {6'd0, data, done_lv, init_lv};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        pins_sb.note_request(func, init_lv, done_lv, data, last);
    endtask

    task automatic wait_pins_drained();
        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && pins_sb.expected_pins.size() != 0; i++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // mostly well-formed sequences steered by the predicted phase, some noise
    task automatic run_random(int count);
        logic [1:0] func;
        bit         init_lv, done_lv, last;
        logic [7:0] data;
        for (int k = 0; k < count; k++) begin
            init_lv = 1'($urandom_range(0, 1));
            done_lv = 1'($urandom_range(0, 1));
            data = 8'($urandom);
            last = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 7) begin
                func = 2'($urandom_range(0, 3));
            end else begin
                case (pins_sb.phase)
                    PH_IDLE:  func = FUNC_START;
                    PH_SHIFT: func = FUNC_BYTE;
                    PH_WAIT_INITL: begin
                        func = FUNC_TICK;
                        init_lv = ($urandom_range(0, 99) < 35);
                    end
                    PH_WAIT_INITH: begin
                        func = FUNC_TICK;
                        init_lv = ($urandom_range(0, 99) >= 35);
                    end
                    default: func = FUNC_TICK;
                endcase
            end
            send_request(func, init_lv, done_lv, data, last);
        end
    endtask

    task automatic load_small_config();
        load_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                    16'($urandom_range(1, 4)), 16'($urandom_range(0, 3)),
                    24'($urandom_range(1, 4)), 8'($urandom_range(0, 4)));
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_START;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short limits so every timeout and every phase is hit
        load_config(16'd0, 16'd0, 16'd2, 16'd0, 24'd2, 8'd1);
        send_request(FUNC_NONE, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_BYTE, 1'b0, 1'b0, 8'hFF, 1'b1);
        // init never goes low
        send_request(FUNC_START, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b1, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b1, 1'b0, 8'h00, 1'b0);
        // init never returns high
        send_request(FUNC_START, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        // full run with two bytes and one trailing clock
        send_request(FUNC_START, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b1, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b1, 1'b1, 8'h00, 1'b0);
        send_request(FUNC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_BYTE, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_request(FUNC_TICK, 1'b0, 1'b0, 8'h00, 1'b0);
        send_request(FUNC_TICK, 1'b0, 1'b1, 8'h00, 1'b0);
        wait_pins_drained();

        // smallest limits, no idling
        load_config(16'd0, 16'd0, 16'd1, 16'd0, 24'd1, 8'd0);
        run_random(60);
        wait_pins_drained();

        idle_pct = 59;
        load_small_config();
        run_random(60);
        wait_pins_drained();

        // receiver stalls, with one long hold-off while requests keep coming
        idle_pct = 0;
        stall_pct = 59;
        load_small_config();
        hold_off = 1'b1;
        run_random(60);
        wait_pins_drained();
        hold_off = 1'b0;

        idle_pct = 10;
        stall_pct = 10;
        load_small_config();
        run_random(60);
        wait_pins_drained();

        // largest limits, only the first steps of a run are reached
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF);
        run_random(20);
        wait_pins_drained();

        if (pins_sb.expected_pins.size() != 0) begin
            pins_sb.errors++;
            $display("%0t: %0d expected results never arrived, expected 0, actual %0d",
                     $time, pins_sb.expected_pins.size(), pins_sb.expected_pins.size());
        end
        $display("run covered %0d requests, %0d pin states checked, %0d register settings",
                 pins_sb.requests, pins_sb.checked, settings);
        $display("outcomes: success %0d, done missing %0d, init stuck high %0d, %s %0d, %s %0d",
                 pins_sb.outcomes[ST_SUCCESS], pins_sb.outcomes[ST_DONE_MISS],
                 pins_sb.outcomes[ST_INIT_STUCKH], "init stuck low",
                 pins_sb.outcomes[ST_INIT_STUCKL], "bytes rejected",
                 pins_sb.outcomes[ST_BYTE_REJECT]);
        if (pins_sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== fpga_serial_config_sequencer_core.f =====
+incdir+hw/rtl
hw/rtl/fscs_pkg.sv
hw/rtl/fscs_regs.sv
hw/rtl/fscs_seq.sv
hw/rtl/fscs_ser.sv
hw/rtl/fpga_serial_config_sequencer_core.sv
hw/rtl/fscs_checker.sv
sim/tb.sv
